[design/mtfb_pkg.sv]
// Shared types and constants for the monochrome text framebuffer.
// Screen geometry, font table size, command codes and sequencer states.
// No dependencies.
`default_nettype none

package mtfb_pkg;

  // Screen and font table geometry
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int FONT_ROWS     = 4096;

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int FRAME_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int FB_AW       = $clog2(FRAME_BYTES);
  localparam int GL_AW       = $clog2(FONT_ROWS);

  // First character code held in the font table
  localparam int FIRST_CHAR = 32;

  // Configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 6;

  typedef enum logic [CFG_IW-1:0] {
    CFG_FONT_WIDTH  = 2'd0,
    CFG_FONT_HEIGHT = 2'd1,
    CFG_INVERT      = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CMD_DRAW_PIXEL = 3'd0,
    CMD_SET_CURSOR = 3'd1,
    CMD_PUT_CHAR   = 3'd2,
    CMD_CLEAR      = 3'd3,
    CMD_LOAD_FONT  = 3'd4,
    CMD_READ_BYTE  = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_CHAR_CHK,
    ST_GLYPH_RD,
    ST_READ_RD,
    ST_READ_DAT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[design/monochrome_text_framebuffer.sv]
// Top level of the monochrome text framebuffer: sequencer, pixel read-modify-write
// unit, cursor and configuration registers. Depends on mtfb_pkg and mtfb_ram.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    command .. read_column (one request)
//   output    out_valid / out_ready  accepted, char_echo, read_byte
//   config    cfg_write              cfg_index, cfg_data (no wait)
//
// One request at a time. Pixel writes go through one read-modify-write unit; the
// frame RAM has one write and one read port. Put char checks the fit, then per glyph
// row reads the glyph table and per column reads and writes a byte. After reset a
// clearing pass writes all FRAME_BYTES (1024) bytes before in_ready rises. A result
// waiting on out_ready does not hold back the next request; that request's result
// waits in the sequencer until the output is free.
`default_nettype none

module monochrome_text_framebuffer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration
  input  wire logic                         cfg_write,
  input  wire logic [mtfb_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [mtfb_pkg::CFG_DW-1:0]  cfg_data,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [2:0]                   command,
  input  wire logic [7:0]                   x_pos,
  input  wire logic [7:0]                   y_pos,
  input  wire logic                         pen_white,
  input  wire logic [7:0]                   char_code,
  input  wire logic [11:0]                  font_row_index,
  input  wire logic [15:0]                  font_row_bits,
  input  wire logic [2:0]                   read_page,
  input  wire logic [6:0]                   read_column,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              accepted,
  output logic [7:0]                        char_echo,
  output logic [7:0]                        read_byte
);

  import mtfb_pkg::*;

  state_t state, state_next;

  // configuration registers
  logic [4:0] font_width;
  logic [5:0] font_height;
  logic       invert_colors;

  // cursor
  logic [7:0] cursor_col;
  logic [7:0] cursor_row;

  // latched request
  logic [7:0] req_x;
  logic [7:0] req_y;
  logic       req_white;
  logic [7:0] req_char;
  logic [2:0] req_page;
  logic [6:0] req_col;

  // sequencer counters
  logic             blit;
  logic [4:0]       cnt_j;
  logic [5:0]       cnt_i;
  logic [GL_AW-1:0] glyph_base;
  logic [FB_AW-1:0] clr_addr;
  logic             clr_cmd;

  // staged result
  logic       res_acc;
  logic [7:0] res_echo;
  logic [7:0] res_byte;

  // RAM ports
  logic             fb_we, fb_re;
  logic [FB_AW-1:0] fb_waddr, fb_raddr;
  logic [7:0]       fb_wdata, fb_rdata;
  logic             gl_we, gl_re;
  logic [GL_AW-1:0] gl_raddr;
  logic [15:0]      gl_rdata;

  logic accept_in;
  logic clr_last;
  logic draw_on, load_ok, read_ok;
  logic [8:0]  col_end, row_end;
  logic [7:0]  ch_off;
  logic [13:0] glyph_base_full;
  logic [14:0] glyph_end;
  logic char_pass, char_empty;
  logic [7:0] pix_x, pix_y;
  logic [FB_AW-1:0] pix_addr, rd_addr;
  logic glyph_bit, pix_white;
  logic [7:0] pix_mask, pix_byte;
  logic last_col, last_row;
  logic out_free;

  assign in_ready  = (state == ST_IDLE);
  assign accept_in = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign clr_last  = (clr_addr == FB_AW'(FRAME_BYTES - 1));

  // Range checks on the incoming request
  assign draw_on = ({1'b0, x_pos} < 9'(SCREEN_WIDTH)) && ({1'b0, y_pos} < 9'(SCREEN_HEIGHT));
  assign load_ok = ({2'b00, font_row_index} < 14'(FONT_ROWS));
  assign read_ok = ({1'b0, read_page} < 4'(PAGE_COUNT)) &&
                   ({2'b00, read_column} < 9'(SCREEN_WIDTH));

  // Character fit and font table checks
  assign col_end         = {1'b0, cursor_col} + 9'(font_width);
  assign row_end         = {1'b0, cursor_row} + 9'(font_height);
  assign ch_off          = req_char - 8'(FIRST_CHAR);
  assign glyph_base_full = 14'(ch_off) * 14'(font_height);
  assign glyph_end       = {1'b0, glyph_base_full} + 15'(font_height);
  assign char_pass       = (col_end < 9'(SCREEN_WIDTH)) && (row_end < 9'(SCREEN_HEIGHT)) &&
                           (req_char >= 8'(FIRST_CHAR)) && (glyph_end <= 15'(FONT_ROWS));
  assign char_empty      = (font_width == 5'd0) || (font_height == 6'd0);

  // Pixel unit: coordinates, address and modified byte
  assign pix_x     = blit ? cursor_col + 8'(cnt_j) : req_x;
  assign pix_y     = blit ? cursor_row + 8'(cnt_i) : req_y;
  assign pix_addr  = FB_AW'(pix_x) + FB_AW'(32'(pix_y[7:3]) * SCREEN_WIDTH);
  assign rd_addr   = FB_AW'(req_col) + FB_AW'(32'(req_page) * SCREEN_WIDTH);
  assign glyph_bit = !cnt_j[4] && gl_rdata[4'd15 - cnt_j[3:0]];
  assign pix_white = (blit ? (req_white ^ !glyph_bit) : req_white) ^ invert_colors;
  assign pix_mask  = 8'd1 << pix_y[2:0];
  assign pix_byte  = pix_white ? (fb_rdata | pix_mask) : (fb_rdata & ~pix_mask);
  assign last_col  = (cnt_j == font_width - 5'd1);
  assign last_row  = (cnt_i == font_height - 6'd1);

  // Load font row writes the glyph table straight from the request
  assign gl_we    = accept_in && (cmd_t'(command) == CMD_LOAD_FONT) && load_ok;
  assign gl_raddr = glyph_base + GL_AW'(cnt_i);

  // Sequencer: next state and RAM strobes
  always_comb begin
    state_next = state;
    fb_we      = 1'b0;
    fb_re      = 1'b0;
    fb_waddr   = pix_addr;
    fb_raddr   = pix_addr;
    fb_wdata   = pix_byte;
    gl_re      = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        fb_we    = 1'b1;
        fb_waddr = clr_addr;
        fb_wdata = 8'd0;
        if (clr_last) begin
          state_next = clr_cmd ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept_in) begin
          unique case (cmd_t'(command))
            CMD_DRAW_PIXEL: state_next = draw_on ? ST_PIX_RD : ST_DONE;
            CMD_PUT_CHAR:   state_next = ST_CHAR_CHK;
            CMD_CLEAR:      state_next = ST_CLEAR;
            CMD_READ_BYTE:  state_next = read_ok ? ST_READ_RD : ST_DONE;
            default:        state_next = ST_DONE;
          endcase
        end
      end
      ST_PIX_RD: begin
        fb_re      = 1'b1;
        state_next = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        fb_we = 1'b1;
        if (!blit) begin
          state_next = ST_DONE;
        end else if (!last_col) begin
          state_next = ST_PIX_RD;
        end else if (!last_row) begin
          state_next = ST_GLYPH_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_CHAR_CHK: begin
        state_next = (char_pass && !char_empty) ? ST_GLYPH_RD : ST_DONE;
      end
      ST_GLYPH_RD: begin
        gl_re      = 1'b1;
        state_next = ST_PIX_RD;
      end
      ST_READ_RD: begin
        fb_re      = 1'b1;
        fb_raddr   = rd_addr;
        state_next = ST_READ_DAT;
      end
      ST_READ_DAT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      font_width    <= 5'd7;
      font_height   <= 6'd10;
      invert_colors <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FONT_WIDTH:  font_width    <= cfg_data[4:0];
        CFG_FONT_HEIGHT: font_height   <= cfg_data[5:0];
        CFG_INVERT:      invert_colors <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Control registers: cursor, counters, clear sweep, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= 8'd0;
      cursor_row <= 8'd0;
      clr_addr   <= '0;
      clr_cmd    <= 1'b0;
      blit       <= 1'b0;
      cnt_i      <= 6'd0;
      cnt_j      <= 5'd0;
      out_valid  <= 1'b0;
    end else begin
      // raise the result when staged, drop it once taken
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + FB_AW'(1);
        end
        ST_IDLE: begin
          if (accept_in) begin
            blit <= 1'b0;
            if (cmd_t'(command) == CMD_SET_CURSOR) begin
              cursor_col <= x_pos;
              cursor_row <= y_pos;
            end
            if (cmd_t'(command) == CMD_CLEAR) begin
              clr_addr <= '0;
              clr_cmd  <= 1'b1;
            end
          end
        end
        ST_CHAR_CHK: begin
          cnt_i <= 6'd0;
          cnt_j <= 5'd0;
          blit  <= char_pass && !char_empty;
          // an empty glyph advances the cursor at once
          if (char_pass && char_empty) begin
            cursor_col <= cursor_col + 8'(font_width);
          end
        end
        ST_PIX_WR: begin
          if (blit) begin
            if (!last_col) begin
              cnt_j <= cnt_j + 5'd1;
            end else begin
              cnt_j <= 5'd0;
              cnt_i <= cnt_i + 6'd1;
              if (last_row) begin
                cursor_col <= cursor_col + 8'(font_width);
              end
            end
          end
        end
        ST_DONE: begin
          clr_cmd <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers: latched request, staged result, output fields
  always_ff @(posedge clk) begin
    if (accept_in) begin
      req_x     <= x_pos;
      req_y     <= y_pos;
      req_white <= pen_white;
      req_char  <= char_code;
      req_page  <= read_page;
      req_col   <= read_column;
      res_echo  <= 8'd0;
      res_byte  <= 8'd0;
      case (cmd_t'(command))
        CMD_DRAW_PIXEL: res_acc <= draw_on;
        CMD_SET_CURSOR: res_acc <= 1'b1;
        CMD_CLEAR:      res_acc <= 1'b1;
        CMD_LOAD_FONT:  res_acc <= load_ok;
        CMD_READ_BYTE:  res_acc <= read_ok;
        default:        res_acc <= 1'b0;
      endcase
    end
    if (state == ST_CHAR_CHK) begin
      glyph_base <= GL_AW'(glyph_base_full);
      if (char_pass) begin
        res_acc  <= 1'b1;
        res_echo <= req_char;
      end
    end
    if (state == ST_READ_DAT) begin
      res_byte <= fb_rdata;
    end
    if ((state == ST_DONE) && out_free) begin
      accepted  <= res_acc;
      char_echo <= res_echo;
      read_byte <= res_byte;
    end
  end

  // Frame store: one byte per column of a page
  mtfb_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (fb_wdata),
    .re    (fb_re),
    .raddr (fb_raddr),
    .rdata (fb_rdata)
  );

  // Glyph table
  mtfb_ram #(
    .WIDTH (16),
    .DEPTH (FONT_ROWS)
  ) u_glyph (
    .clk   (clk),
    .we    (gl_we),
    .waddr (GL_AW'(font_row_index)),
    .wdata (font_row_bits),
    .re    (gl_re),
    .raddr (gl_raddr),
    .rdata (gl_rdata)
  );

endmodule

`default_nettype wire

[design/mtfb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the frame store and the glyph table. No dependencies.
`default_nettype none

module mtfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
